// ===== rtl/core/gtd_pkg.sv =====
package gtd_pkg;

  // graph sizing
  localparam int unsigned NumV     = 64;
  localparam int unsigned VW       = 6;
  localparam int unsigned KeyW     = 2 * VW;
  localparam int unsigned KeyDepth = NumV * NumV;
  localparam int unsigned MaxEdges = 2016;
  localparam int unsigned PosW     = 11;
  localparam int unsigned SupW     = 6;
  localparam int unsigned ClsW     = 7;
  localparam int unsigned MinClass = 2;

  // input request fields
  typedef struct packed {
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
    logic          last_edge;
  } in_req_t;

  // result fields
  typedef struct packed {
    logic [ClsW-1:0] max_truss_number;
    logic [PosW-1:0] edges_in_top_class;
    logic [PosW-1:0] edge_count;
  } res_t;

  // adjacency row store access
  typedef struct packed {
    logic            we;
    logic [VW-1:0]   waddr;
    logic [NumV-1:0] wdata;
    logic [VW-1:0]   raddr_a;
    logic [VW-1:0]   raddr_b;
  } adj_req_t;

  // truss class record
  typedef struct packed {
    logic            valid;
    logic            clear;
    logic [ClsW-1:0] cls;
  } cls_rec_t;

  // sequencer states
  typedef enum logic [5:0] {
    ST_CLR, ST_IDLE,
    ST_IN_RD, ST_IN_CHK, ST_IN_WA, ST_IN_WB, ST_IN_SCAN, ST_IN_IA, ST_IN_IB, ST_IN_SAVE,
    ST_BCLR, ST_S1_RD, ST_S1_CK, ST_S1_WR, ST_PF_RD, ST_PF_WR,
    ST_S2_RD, ST_S2_CK, ST_S2_WR, ST_SH_RD, ST_SH_WR, ST_SH_Z,
    ST_PL_RD, ST_PL_KEY, ST_PL_SUP, ST_PL_SCAN,
    ST_LO_RD, ST_LO_S, ST_LO_PH, ST_LO_SW, ST_LO_SW2, ST_LO_NEXT,
    ST_PL_DA, ST_PL_DB, ST_OUT
  } state_e;

  // edge key: lower vertex in the upper bits
  function automatic logic [KeyW-1:0] edge_key(logic [VW-1:0] x, logic [VW-1:0] y);
    edge_key = (x < y) ? {x, y} : {y, x};
  endfunction

  // single bit of an adjacency row
  function automatic logic [NumV-1:0] row_bit(logic [VW-1:0] x);
    row_bit = NumV'(1) << x;
  endfunction

endpackage

// ===== rtl/core/gtd_ram.sv =====
module gtd_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/gtd_adj_mem.sv =====
module gtd_adj_mem (
  input  logic                      clk_i,
  input  gtd_pkg::adj_req_t         req_i,
  output logic [gtd_pkg::NumV-1:0]  rdata_a_o,
  output logic [gtd_pkg::NumV-1:0]  rdata_b_o
);

  logic [gtd_pkg::NumV-1:0] rows [gtd_pkg::NumV];

  // one row written, two rows read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      rows[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_o <= rows[req_i.raddr_a];
    rdata_b_o <= rows[req_i.raddr_b];
  end

endmodule

// ===== rtl/core/gtd_class_trk.sv =====
module gtd_class_trk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gtd_pkg::cls_rec_t          rec_i,
  output logic [gtd_pkg::ClsW-1:0]   peak_o,
  output logic [gtd_pkg::PosW-1:0]   count_o
);

  logic [gtd_pkg::ClsW-1:0] cls;
  logic [gtd_pkg::ClsW-1:0] peak_q;
  logic [gtd_pkg::PosW-1:0] count_q;

  // classes saturate at the vertex count
  assign cls = (rec_i.cls > gtd_pkg::ClsW'(gtd_pkg::NumV)) ?
               gtd_pkg::ClsW'(gtd_pkg::NumV) : rec_i.cls;

  // running top class and its population
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      count_q <= '0;
    end else if (rec_i.clear) begin
      peak_q  <= '0;
      count_q <= '0;
    end else if (rec_i.valid) begin
      if (cls > peak_q) begin
        peak_q  <= cls;
        count_q <= gtd_pkg::PosW'(1);
      end else if (cls == peak_q) begin
        count_q <= count_q + gtd_pkg::PosW'(1);
      end
    end
  end

  assign peak_o  = peak_q;
  assign count_o = count_q;

endmodule

// ===== rtl/core/graph_truss_decomposition_unit.sv =====
// channel  | direction | handshake            | payload
// request  | in        | start high, busy low | req_i   (vertex_a, vertex_b, last_edge)
// result   | out       | valid_o for 1 cycle  | res_o   (max_truss_number, edges_in_top_class,
//          |           |                      |          edge_count)
// an edge insert reads both rows, writes them back with the new edge, scans the neighbours and
// updates the partner supports of each closed triangle; a self-loop, repeat or edge beyond the store is skipped
// the final request adds two passes over all edge keys and a bin sort, then per peeled edge
// a neighbour scan, a check of each partner edge and a move down one bin for each partner
// with higher support, then the result; each store does its reads and writes in turn
// after reset and after every result a pass clears the adjacency rows (busy high)
// the receiver cannot stall: a result is taken in the cycle valid_o is high
module graph_truss_decomposition_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  gtd_pkg::in_req_t    req_i,
  output logic                valid_o,
  output gtd_pkg::res_t       res_o
);

  localparam int unsigned VW   = gtd_pkg::VW;
  localparam int unsigned KeyW = gtd_pkg::KeyW;
  localparam int unsigned PosW = gtd_pkg::PosW;
  localparam int unsigned SupW = gtd_pkg::SupW;
  localparam int unsigned NumV = gtd_pkg::NumV;

  gtd_pkg::state_e state_q, state_d;

  logic [VW-1:0]   a_q, b_q, w_q, bidx_q;
  logic            last_q, side_q;
  logic [KeyW-1:0] key_q, tgt_q, other_q;
  logic [PosW-1:0] pos_q, m_q, total_q, loaded_q, p_q, head_q;
  logic [NumV-1:0] row_a_q, row_b_q, common;
  logic [SupW-1:0] sup_q, found_q, s_q;

  gtd_pkg::adj_req_t adj_req;
  gtd_pkg::cls_rec_t rec;
  logic [NumV-1:0]   adj_rd_a, adj_rd_b;

  logic            sup_we, slot_we, srt_we, bin_we;
  logic [KeyW-1:0] sup_waddr, sup_raddr, slot_waddr, slot_raddr;
  logic [SupW-1:0] sup_wdata, sup_rd;
  logic [PosW-1:0] slot_wdata, slot_rd, srt_waddr, srt_raddr, bin_wdata, bin_rd;
  logic [KeyW-1:0] srt_wdata, srt_rd;
  logic [VW-1:0]   bin_waddr, bin_raddr;

  logic [gtd_pkg::ClsW-1:0] peak;
  logic [PosW-1:0]          top_count;

  logic scan_edge, w_last, key_last, in_skip;

  // stores
  gtd_adj_mem u_adj (
    .clk_i     (clk_i),
    .req_i     (adj_req),
    .rdata_a_o (adj_rd_a),
    .rdata_b_o (adj_rd_b)
  );

  gtd_ram #(.Depth(gtd_pkg::KeyDepth), .Width(SupW)) u_sup (
    .clk_i(clk_i), .we_i(sup_we), .waddr_i(sup_waddr), .wdata_i(sup_wdata),
    .raddr_i(sup_raddr), .rdata_o(sup_rd)
  );

  gtd_ram #(.Depth(gtd_pkg::KeyDepth), .Width(PosW)) u_slot (
    .clk_i(clk_i), .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(slot_wdata),
    .raddr_i(slot_raddr), .rdata_o(slot_rd)
  );

  gtd_ram #(.Depth(gtd_pkg::MaxEdges), .Width(KeyW)) u_srt (
    .clk_i(clk_i), .we_i(srt_we), .waddr_i(srt_waddr), .wdata_i(srt_wdata),
    .raddr_i(srt_raddr), .rdata_o(srt_rd)
  );

  gtd_ram #(.Depth(NumV), .Width(PosW)) u_bin (
    .clk_i(clk_i), .we_i(bin_we), .waddr_i(bin_waddr), .wdata_i(bin_wdata),
    .raddr_i(bin_raddr), .rdata_o(bin_rd)
  );

  gtd_class_trk u_cls (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (rec),
    .peak_o  (peak),
    .count_o (top_count)
  );

  // shared decode
  assign common    = row_a_q & row_b_q;
  assign w_last    = (w_q == VW'(NumV - 1));
  assign key_last  = (key_q == KeyW'(gtd_pkg::KeyDepth - 1));
  assign scan_edge = adj_rd_a[key_q[VW-1:0]] && (key_q[VW-1:0] > key_q[KeyW-1:VW]);
  assign in_skip   = (a_q == b_q) || adj_rd_a[b_q] || (loaded_q >= PosW'(gtd_pkg::MaxEdges));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gtd_pkg::ST_CLR:     if (w_last) state_d = gtd_pkg::ST_IDLE;
      gtd_pkg::ST_IDLE:    if (start) state_d = gtd_pkg::ST_IN_RD;
      gtd_pkg::ST_IN_RD:   state_d = gtd_pkg::ST_IN_CHK;
      gtd_pkg::ST_IN_CHK: begin
        if (!in_skip) state_d = gtd_pkg::ST_IN_WA;
        else if (last_q) state_d = gtd_pkg::ST_BCLR;
        else state_d = gtd_pkg::ST_IDLE;
      end
      gtd_pkg::ST_IN_WA:   state_d = gtd_pkg::ST_IN_WB;
      gtd_pkg::ST_IN_WB:   state_d = gtd_pkg::ST_IN_SCAN;
      gtd_pkg::ST_IN_SCAN: begin
        if (common[w_q]) state_d = gtd_pkg::ST_IN_IA;
        else if (w_last) state_d = gtd_pkg::ST_IN_SAVE;
      end
      gtd_pkg::ST_IN_IA:   state_d = gtd_pkg::ST_IN_IB;
      gtd_pkg::ST_IN_IB:   state_d = w_last ? gtd_pkg::ST_IN_SAVE : gtd_pkg::ST_IN_SCAN;
      gtd_pkg::ST_IN_SAVE: state_d = last_q ? gtd_pkg::ST_BCLR : gtd_pkg::ST_IDLE;
      gtd_pkg::ST_BCLR:    if (bidx_q == VW'(NumV - 1)) state_d = gtd_pkg::ST_S1_RD;
      gtd_pkg::ST_S1_RD:   state_d = gtd_pkg::ST_S1_CK;
      gtd_pkg::ST_S1_CK: begin
        if (scan_edge && (sup_rd != '0)) state_d = gtd_pkg::ST_S1_WR;
        else if (key_last) state_d = gtd_pkg::ST_PF_RD;
        else state_d = gtd_pkg::ST_S1_RD;
      end
      gtd_pkg::ST_S1_WR:   state_d = key_last ? gtd_pkg::ST_PF_RD : gtd_pkg::ST_S1_RD;
      gtd_pkg::ST_PF_RD:   state_d = gtd_pkg::ST_PF_WR;
      gtd_pkg::ST_PF_WR: begin
        state_d = (bidx_q == VW'(NumV - 1)) ? gtd_pkg::ST_S2_RD : gtd_pkg::ST_PF_RD;
      end
      gtd_pkg::ST_S2_RD:   state_d = gtd_pkg::ST_S2_CK;
      gtd_pkg::ST_S2_CK: begin
        if (scan_edge && (sup_rd != '0)) state_d = gtd_pkg::ST_S2_WR;
        else if (key_last) state_d = gtd_pkg::ST_SH_RD;
        else state_d = gtd_pkg::ST_S2_RD;
      end
      gtd_pkg::ST_S2_WR:   state_d = key_last ? gtd_pkg::ST_SH_RD : gtd_pkg::ST_S2_RD;
      gtd_pkg::ST_SH_RD:   state_d = gtd_pkg::ST_SH_WR;
      gtd_pkg::ST_SH_WR:   state_d = (bidx_q == VW'(1)) ? gtd_pkg::ST_SH_Z : gtd_pkg::ST_SH_RD;
      gtd_pkg::ST_SH_Z:    state_d = (m_q == '0) ? gtd_pkg::ST_OUT : gtd_pkg::ST_PL_RD;
      gtd_pkg::ST_PL_RD:   state_d = gtd_pkg::ST_PL_KEY;
      gtd_pkg::ST_PL_KEY:  state_d = gtd_pkg::ST_PL_SUP;
      gtd_pkg::ST_PL_SUP:  state_d = gtd_pkg::ST_PL_SCAN;
      gtd_pkg::ST_PL_SCAN: begin
        if (found_q == sup_q) state_d = gtd_pkg::ST_PL_DA;
        else if (common[w_q]) state_d = gtd_pkg::ST_LO_RD;
        else if (w_last) state_d = gtd_pkg::ST_PL_DA;
      end
      gtd_pkg::ST_LO_RD:   state_d = gtd_pkg::ST_LO_S;
      gtd_pkg::ST_LO_S:    state_d = (sup_rd <= sup_q) ? gtd_pkg::ST_LO_NEXT : gtd_pkg::ST_LO_PH;
      gtd_pkg::ST_LO_PH:   state_d = gtd_pkg::ST_LO_SW;
      gtd_pkg::ST_LO_SW:   state_d = gtd_pkg::ST_LO_SW2;
      gtd_pkg::ST_LO_SW2:  state_d = gtd_pkg::ST_LO_NEXT;
      gtd_pkg::ST_LO_NEXT: begin
        if (!side_q) state_d = gtd_pkg::ST_LO_RD;
        else if (w_last) state_d = gtd_pkg::ST_PL_DA;
        else state_d = gtd_pkg::ST_PL_SCAN;
      end
      gtd_pkg::ST_PL_DA:   state_d = gtd_pkg::ST_PL_DB;
      gtd_pkg::ST_PL_DB: begin
        state_d = ((pos_q + PosW'(1)) == m_q) ? gtd_pkg::ST_OUT : gtd_pkg::ST_PL_RD;
      end
      gtd_pkg::ST_OUT:     state_d = gtd_pkg::ST_CLR;
      default:             state_d = gtd_pkg::ST_CLR;
    endcase
  end

  // store ports and outputs
  always_comb begin
    adj_req    = '0;
    rec        = '0;
    sup_we     = 1'b0;
    sup_waddr  = '0;
    sup_wdata  = '0;
    sup_raddr  = '0;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    slot_raddr = '0;
    srt_we     = 1'b0;
    srt_waddr  = '0;
    srt_wdata  = '0;
    srt_raddr  = '0;
    bin_we     = 1'b0;
    bin_waddr  = '0;
    bin_wdata  = '0;
    bin_raddr  = '0;
    case (state_q)
      gtd_pkg::ST_CLR: begin
        adj_req.we    = 1'b1;
        adj_req.waddr = w_q;
      end
      gtd_pkg::ST_IN_RD: begin
        adj_req.raddr_a = a_q;
        adj_req.raddr_b = b_q;
      end
      gtd_pkg::ST_IN_WA: begin
        adj_req.we    = 1'b1;
        adj_req.waddr = a_q;
        adj_req.wdata = row_a_q | gtd_pkg::row_bit(b_q);
      end
      gtd_pkg::ST_IN_WB: begin
        adj_req.we    = 1'b1;
        adj_req.waddr = b_q;
        adj_req.wdata = row_b_q | gtd_pkg::row_bit(a_q);
      end
      gtd_pkg::ST_IN_SCAN: sup_raddr = gtd_pkg::edge_key(a_q, w_q);
      gtd_pkg::ST_IN_IA: begin
        sup_we    = 1'b1;
        sup_waddr = gtd_pkg::edge_key(a_q, w_q);
        sup_wdata = sup_rd + SupW'(1);
        sup_raddr = gtd_pkg::edge_key(b_q, w_q);
      end
      gtd_pkg::ST_IN_IB: begin
        sup_we    = 1'b1;
        sup_waddr = gtd_pkg::edge_key(b_q, w_q);
        sup_wdata = sup_rd + SupW'(1);
      end
      gtd_pkg::ST_IN_SAVE: begin
        sup_we    = 1'b1;
        sup_waddr = gtd_pkg::edge_key(a_q, b_q);
        sup_wdata = sup_q;
      end
      gtd_pkg::ST_BCLR: begin
        bin_we    = 1'b1;
        bin_waddr = bidx_q;
      end
      gtd_pkg::ST_S1_RD, gtd_pkg::ST_S2_RD: begin
        adj_req.raddr_a = key_q[KeyW-1:VW];
        sup_raddr       = key_q;
      end
      gtd_pkg::ST_S1_CK: begin
        bin_raddr = sup_rd;
        rec.valid = scan_edge && (sup_rd == '0);
        rec.cls   = gtd_pkg::ClsW'(gtd_pkg::MinClass);
      end
      gtd_pkg::ST_S2_CK: bin_raddr = sup_rd;
      gtd_pkg::ST_S1_WR: begin
        bin_we    = 1'b1;
        bin_waddr = s_q;
        bin_wdata = bin_rd + PosW'(1);
      end
      gtd_pkg::ST_PF_RD: bin_raddr = bidx_q;
      gtd_pkg::ST_PF_WR: begin
        bin_we    = 1'b1;
        bin_waddr = bidx_q;
        bin_wdata = total_q;
      end
      gtd_pkg::ST_S2_WR: begin
        srt_we     = 1'b1;
        srt_waddr  = bin_rd;
        srt_wdata  = key_q;
        slot_we    = 1'b1;
        slot_waddr = key_q;
        slot_wdata = bin_rd;
        bin_we     = 1'b1;
        bin_waddr  = s_q;
        bin_wdata  = bin_rd + PosW'(1);
      end
      gtd_pkg::ST_SH_RD: bin_raddr = bidx_q - VW'(1);
      gtd_pkg::ST_SH_WR: begin
        bin_we    = 1'b1;
        bin_waddr = bidx_q;
        bin_wdata = bin_rd;
      end
      gtd_pkg::ST_SH_Z: bin_we = 1'b1;
      gtd_pkg::ST_PL_RD: srt_raddr = pos_q;
      gtd_pkg::ST_PL_KEY: begin
        adj_req.raddr_a = srt_rd[KeyW-1:VW];
        adj_req.raddr_b = srt_rd[VW-1:0];
        sup_raddr       = srt_rd;
      end
      gtd_pkg::ST_PL_SUP: begin
        rec.valid = 1'b1;
        rec.cls   = gtd_pkg::ClsW'(sup_rd) + gtd_pkg::ClsW'(gtd_pkg::MinClass);
      end
      gtd_pkg::ST_LO_RD: sup_raddr = tgt_q;
      gtd_pkg::ST_LO_S: begin
        slot_raddr = tgt_q;
        bin_raddr  = sup_rd;
      end
      gtd_pkg::ST_LO_PH: srt_raddr = bin_rd;
      gtd_pkg::ST_LO_SW: begin
        bin_we     = 1'b1;
        bin_waddr  = s_q;
        bin_wdata  = head_q + PosW'(1);
        sup_we     = 1'b1;
        sup_waddr  = tgt_q;
        sup_wdata  = s_q - SupW'(1);
        slot_we    = (p_q != head_q);
        slot_waddr = tgt_q;
        slot_wdata = head_q;
        srt_we     = (p_q != head_q);
        srt_waddr  = p_q;
        srt_wdata  = srt_rd;
      end
      gtd_pkg::ST_LO_SW2: begin
        slot_we    = (p_q != head_q);
        slot_waddr = other_q;
        slot_wdata = p_q;
        srt_we     = (p_q != head_q);
        srt_waddr  = head_q;
        srt_wdata  = tgt_q;
      end
      gtd_pkg::ST_PL_DA: begin
        adj_req.we    = 1'b1;
        adj_req.waddr = a_q;
        adj_req.wdata = row_a_q & ~gtd_pkg::row_bit(b_q);
      end
      gtd_pkg::ST_PL_DB: begin
        adj_req.we    = 1'b1;
        adj_req.waddr = b_q;
        adj_req.wdata = row_b_q & ~gtd_pkg::row_bit(a_q);
      end
      gtd_pkg::ST_OUT: rec.clear = 1'b1;
      default: ;
    endcase
  end

  assign busy    = (state_q != gtd_pkg::ST_IDLE);
  assign valid_o = (state_q == gtd_pkg::ST_OUT);
  assign res_o.max_truss_number   = peak;
  assign res_o.edges_in_top_class = (peak != '0) ? top_count : '0;
  assign res_o.edge_count         = loaded_q;

  // state and control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gtd_pkg::ST_CLR;
      w_q      <= '0;
      loaded_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        gtd_pkg::ST_CLR:     w_q <= w_q + VW'(1);
        gtd_pkg::ST_IN_WB: begin
          w_q      <= '0;
          loaded_q <= loaded_q + PosW'(1);
        end
        gtd_pkg::ST_IN_SCAN: if (!common[w_q] && !w_last) w_q <= w_q + VW'(1);
        gtd_pkg::ST_IN_IB:   if (!w_last) w_q <= w_q + VW'(1);
        gtd_pkg::ST_PL_SUP:  w_q <= '0;
        gtd_pkg::ST_PL_SCAN: begin
          if ((found_q != sup_q) && !common[w_q] && !w_last) w_q <= w_q + VW'(1);
        end
        gtd_pkg::ST_LO_NEXT: if (side_q && !w_last) w_q <= w_q + VW'(1);
        gtd_pkg::ST_OUT: begin
          w_q      <= '0;
          loaded_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      gtd_pkg::ST_IDLE: begin
        a_q    <= req_i.vertex_a;
        b_q    <= req_i.vertex_b;
        last_q <= req_i.last_edge;
        bidx_q <= '0;
      end
      gtd_pkg::ST_IN_CHK: begin
        row_a_q <= adj_rd_a;
        row_b_q <= adj_rd_b;
        sup_q   <= '0;
      end
      gtd_pkg::ST_IN_IB: sup_q <= sup_q + SupW'(1);
      gtd_pkg::ST_BCLR: begin
        bidx_q <= bidx_q + VW'(1);
        key_q  <= '0;
        m_q    <= '0;
      end
      gtd_pkg::ST_S1_CK: begin
        s_q <= sup_rd;
        if (!(scan_edge && (sup_rd != '0))) begin
          key_q   <= key_q + KeyW'(1);
          total_q <= '0;
        end
      end
      gtd_pkg::ST_S1_WR: begin
        m_q     <= m_q + PosW'(1);
        key_q   <= key_q + KeyW'(1);
        total_q <= '0;
      end
      gtd_pkg::ST_PF_WR: begin
        total_q <= total_q + bin_rd;
        bidx_q  <= bidx_q + VW'(1);
        key_q   <= '0;
      end
      gtd_pkg::ST_S2_CK: begin
        s_q <= sup_rd;
        if (!(scan_edge && (sup_rd != '0))) begin
          key_q  <= key_q + KeyW'(1);
          bidx_q <= VW'(NumV - 1);
        end
      end
      gtd_pkg::ST_S2_WR: begin
        key_q  <= key_q + KeyW'(1);
        bidx_q <= VW'(NumV - 1);
      end
      gtd_pkg::ST_SH_WR: bidx_q <= bidx_q - VW'(1);
      gtd_pkg::ST_SH_Z:  pos_q <= '0;
      gtd_pkg::ST_PL_KEY: begin
        a_q <= srt_rd[KeyW-1:VW];
        b_q <= srt_rd[VW-1:0];
      end
      gtd_pkg::ST_PL_SUP: begin
        row_a_q <= adj_rd_a;
        row_b_q <= adj_rd_b;
        sup_q   <= sup_rd;
        found_q <= '0;
      end
      gtd_pkg::ST_PL_SCAN: begin
        // only a closed triangle counts towards the partners found
        if (common[w_q]) found_q <= found_q + SupW'(1);
        tgt_q   <= gtd_pkg::edge_key(a_q, w_q);
        side_q  <= 1'b0;
      end
      gtd_pkg::ST_LO_S:  s_q <= sup_rd;
      gtd_pkg::ST_LO_PH: begin
        p_q    <= slot_rd;
        head_q <= bin_rd;
      end
      gtd_pkg::ST_LO_SW: other_q <= srt_rd;
      gtd_pkg::ST_LO_NEXT: begin
        side_q <= 1'b1;
        tgt_q  <= gtd_pkg::edge_key(b_q, w_q);
      end
      gtd_pkg::ST_PL_DB: pos_q <= pos_q + PosW'(1);
      default: ;
    endcase
  end

  // checks
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result outside a busy phase");

  a_out_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_top_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.edges_in_top_class <= res_o.edge_count))
    else $error("top class holds more edges than were loaded");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request taken without going busy");

endmodule

// ===== dv/graph_truss_decomposition_checker.sv =====
module graph_truss_decomposition_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  gtd_pkg::in_req_t  req_i,
  input  logic              valid_o,
  input  gtd_pkg::res_t     res_o,
  output int                fail_count_o,
  output int                pending_o
);

  // shadow copy of the graph store
  bit          adj_q[gtd_pkg::KeyDepth];
  int unsigned support_q[gtd_pkg::KeyDepth];
  int unsigned slot_q[gtd_pkg::KeyDepth];
  int unsigned order_q[gtd_pkg::MaxEdges];
  int unsigned bin_head_q[gtd_pkg::NumV+1];
  int unsigned class_tally_q[gtd_pkg::NumV+1];
  int unsigned edges_held_q;
  int unsigned top_class_q;

  gtd_pkg::res_t truss_results_q[$];
  int            fail_count;
  int            pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic int unsigned pair_key(int unsigned a, int unsigned b);
    return (a < b) ? a * gtd_pkg::NumV + b : b * gtd_pkg::NumV + a;
  endfunction

  function automatic void clear_graph();
    foreach (adj_q[i]) begin
      adj_q[i]     = 0;
      support_q[i] = 0;
      slot_q[i]    = 0;
    end
    foreach (order_q[i]) order_q[i] = 0;
    foreach (bin_head_q[i]) begin
      bin_head_q[i]    = 0;
      class_tally_q[i] = 0;
    end
    edges_held_q = 0;
    top_class_q  = 0;
  endfunction

  // new edge plus triangle support update
  function automatic void add_edge(int unsigned a, int unsigned b);
    int unsigned e;
    if (a == b || adj_q[a*gtd_pkg::NumV+b] || edges_held_q >= gtd_pkg::MaxEdges) return;
    adj_q[a*gtd_pkg::NumV+b] = 1;
    adj_q[b*gtd_pkg::NumV+a] = 1;
    e = pair_key(a, b);
    support_q[e] = 0;
    edges_held_q++;
    for (int unsigned w = 0; w < gtd_pkg::NumV; w++) begin
      if (w == a || w == b) continue;
      if (adj_q[a*gtd_pkg::NumV+w] && adj_q[b*gtd_pkg::NumV+w]) begin
        support_q[e]++;
        support_q[pair_key(a, w)]++;
        support_q[pair_key(b, w)]++;
      end
    end
  endfunction

  function automatic void log_class(int unsigned c);
    if (c > gtd_pkg::NumV) c = gtd_pkg::NumV;
    class_tally_q[c]++;
    if (c > top_class_q) top_class_q = c;
  endfunction

  // partner edge moves down one support bin
  function automatic void lower_partner(int unsigned e, int unsigned floor_sup);
    int unsigned s, p, head, other;
    s = support_q[e];
    if (s <= floor_sup || s > gtd_pkg::NumV) return;
    p    = slot_q[e];
    head = bin_head_q[s];
    if (p >= gtd_pkg::MaxEdges || head >= gtd_pkg::MaxEdges) return;
    other = order_q[head];
    if (p != head) begin
      slot_q[e]                          = head;
      slot_q[other % gtd_pkg::KeyDepth]  = p;
      order_q[p]                         = other;
      order_q[head]                      = e;
    end
    bin_head_q[s]++;
    support_q[e] = s - 1;
  endfunction

  // bin sort then peel in order of least support
  function automatic void peel_graph();
    int unsigned s, e, m, top, total, size, found, sup, u, v;
    m = 0; top = 0; total = 0;
    foreach (bin_head_q[i]) bin_head_q[i] = 0;
    for (int unsigned x = 0; x < gtd_pkg::NumV; x++)
      for (int unsigned y = x + 1; y < gtd_pkg::NumV; y++) begin
        if (!adj_q[x*gtd_pkg::NumV+y]) continue;
        s = support_q[x*gtd_pkg::NumV+y];
        if (s == 0) begin
          log_class(gtd_pkg::MinClass);
          adj_q[x*gtd_pkg::NumV+y] = 0;
          adj_q[y*gtd_pkg::NumV+x] = 0;
          continue;
        end
        if (s > gtd_pkg::NumV - 2) s = gtd_pkg::NumV - 2;
        m++;
        bin_head_q[s]++;
        if (s > top) top = s;
      end
    for (int unsigned i = 0; i <= top; i++) begin
      size          = bin_head_q[i];
      bin_head_q[i] = total;
      total        += size;
    end
    for (int unsigned x = 0; x < gtd_pkg::NumV; x++)
      for (int unsigned y = x + 1; y < gtd_pkg::NumV; y++) begin
        if (!adj_q[x*gtd_pkg::NumV+y]) continue;
        e = x * gtd_pkg::NumV + y;
        s = support_q[e];
        if (bin_head_q[s] >= gtd_pkg::MaxEdges) continue;
        order_q[bin_head_q[s]] = e;
        slot_q[e]              = bin_head_q[s];
        bin_head_q[s]++;
      end
    for (int unsigned i = top + 1; i > 0; i--) bin_head_q[i] = bin_head_q[i-1];
    bin_head_q[0] = 0;
    if (m > gtd_pkg::MaxEdges) m = gtd_pkg::MaxEdges;
    for (int unsigned i = 0; i < m; i++) begin
      e     = order_q[i] % gtd_pkg::KeyDepth;
      u     = e / gtd_pkg::NumV;
      v     = e % gtd_pkg::NumV;
      sup   = support_q[e];
      found = 0;
      log_class(sup + gtd_pkg::MinClass);
      for (int unsigned w = 0; w < gtd_pkg::NumV; w++) begin
        if (found == sup) break;
        if (w == u || w == v) continue;
        if (adj_q[u*gtd_pkg::NumV+w] && adj_q[v*gtd_pkg::NumV+w]) begin
          found++;
          lower_partner(pair_key(u, w), sup);
          lower_partner(pair_key(v, w), sup);
        end
      end
      adj_q[u*gtd_pkg::NumV+v] = 0;
      adj_q[v*gtd_pkg::NumV+u] = 0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    clear_graph();
  end

  // predict on each accepted request, compare each result
  always @(posedge clk_i) begin
    gtd_pkg::res_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (truss_results_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = truss_results_q.pop_front();
          if (res_o.max_truss_number !== want.max_truss_number)
            report_mismatch("max_truss_number", res_o.max_truss_number, want.max_truss_number);
          if (res_o.edges_in_top_class !== want.edges_in_top_class)
            report_mismatch("edges_in_top_class", res_o.edges_in_top_class,
                            want.edges_in_top_class);
          if (res_o.edge_count !== want.edge_count)
            report_mismatch("edge_count", res_o.edge_count, want.edge_count);
        end
      end
      if (start && !busy) begin
        add_edge(req_i.vertex_a, req_i.vertex_b);
        if (req_i.last_edge) begin
          peel_graph();
          want.max_truss_number   = gtd_pkg::ClsW'(top_class_q);
          want.edges_in_top_class =
            gtd_pkg::PosW'(top_class_q ? class_tally_q[top_class_q] : 0);
          want.edge_count         = gtd_pkg::PosW'(edges_held_q);
          truss_results_q         = {truss_results_q, want};
          clear_graph();
        end
      end
      pending = truss_results_q.size();
    end
  end

endmodule

// ===== dv/graph_truss_decomposition_unit_test.sv =====
module graph_truss_decomposition_unit_test;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  gtd_pkg::in_req_t req_i;
  logic             valid_o;
  gtd_pkg::res_t    res_o;
  int               fail_count;
  int               pending;
  int               sent;
  bit               idling_on;

  graph_truss_decomposition_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  graph_truss_decomposition_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .valid_o      (valid_o),
    .res_o        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // one edge request, with an optional idle burst in front
  task automatic send_edge(int unsigned a, int unsigned b, bit last);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    req_i.vertex_a  <= gtd_pkg::VW'(a);
    req_i.vertex_b  <= gtd_pkg::VW'(b);
    req_i.last_edge <= last;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic send_clique(int unsigned base, int unsigned n, bit last);
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = i + 1; j < n; j++)
        send_edge(base + i, base + j, last && (i == n - 2));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    #(10 * 40_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned span, base, n, a, b, pa, pb;
    start     = 1'b0;
    req_i     = '0;
    rst_ni    = 1'b0;
    sent      = 0;
    idling_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty graph: a lone self-loop as the final request
    send_edge(0, 0, 1);
    // triangle with a repeat the other way round, a self-loop and a pendant edge
    send_edge(0, 63, 0);
    send_edge(63, 0, 0);
    send_edge(63, 62, 0);
    send_edge(5, 5, 0);
    send_edge(10, 11, 0);
    send_edge(0, 62, 1);
    // only zero-support edges, final request a repeat
    send_edge(1, 2, 0);
    send_edge(3, 4, 0);
    send_edge(2, 1, 1);
    // a clique of five
    send_clique(20, 5, 1);
    wait_drained();

    // random graphs on small vertex windows, sometimes wide or a larger clique
    while (sent < 1800) begin
      if (sent > 1500) idling_on = 1'b0;
      if ($urandom_range(0, 15) == 0) begin
        send_clique($urandom_range(0, 48), $urandom_range(6, 16), 1);
        continue;
      end
      span = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(3, 12);
      base = $urandom_range(0, 64 - span);
      n    = $urandom_range(1, 60);
      pa = base; pb = base;
      for (int unsigned k = 0; k < n; k++) begin
        case ($urandom_range(0, 9))
          0: begin a = base + $urandom_range(0, span - 1); b = a; end
          1: begin a = pb; b = pa; end
          default: begin
            a = base + $urandom_range(0, span - 1);
            b = base + $urandom_range(0, span - 1);
          end
        endcase
        send_edge(a, b, k == n - 1);
        pa = a; pb = b;
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gtd_pkg.sv
rtl/core/gtd_ram.sv
rtl/core/gtd_adj_mem.sv
rtl/core/gtd_class_trk.sv
rtl/core/graph_truss_decomposition_unit.sv
dv/graph_truss_decomposition_checker.sv
dv/graph_truss_decomposition_unit_test.sv
